>>> design/lph_pkg.sv
package lph_pkg;

    localparam int KEY_W        = 32;
    localparam int SLOT_INDEX_W = 4;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

>>> design/lph_home_slot.sv
module lph_home_slot
    import lph_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [KEY_W-1:0]              key,
    output logic                          done,
    output logic [$clog2(SLOT_COUNT)-1:0] home
);

    localparam int SW     = $clog2(SLOT_COUNT);
    localparam int PROD_W = 2 * KEY_W;
    localparam int SHIFT  = KEY_W - 1 + SW;
    localparam logic [PROD_W-1:0] RECIP_WIDE = (PROD_W'(1) << SHIFT) / PROD_W'(SLOT_COUNT);
    localparam logic [KEY_W-1:0]  RECIP      = RECIP_WIDE[KEY_W-1:0];
    localparam logic [KEY_W-1:0]  MOD        = KEY_W'(SLOT_COUNT);
    localparam logic [1:0]        LAST_STEP  = 2'd2;

    logic              busy_reg;
    logic [1:0]        step_reg;
    logic [KEY_W-1:0]  key_pos_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] quot_wide;
    logic [KEY_W-1:0]  quot;
    logic [KEY_W-1:0]  diff_reg;
    logic [KEY_W-1:0]  rem_fix;

    // quotient estimate from the reciprocal, at most one short of exact
    assign quot_wide = prod_reg >> SHIFT;
    assign quot      = quot_wide[KEY_W-1:0];

    // one correction step brings the remainder below the slot count
    assign rem_fix = (diff_reg >= MOD) ? diff_reg - MOD : diff_reg;

    assign done = busy_reg && (step_reg == LAST_STEP);
    assign home = rem_fix[SW-1:0];

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // negative keys hash to slot zero; multiply, then multiply-subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_pos_reg <= key[KEY_W-1] ? '0 : key;
        end
        prod_reg <= {{KEY_W{1'b0}}, key_pos_reg} * {{KEY_W{1'b0}}, RECIP};
        diff_reg <= key_pos_reg - quot * MOD;
    end

endmodule

>>> design/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing.
// Input channel (in_valid/in_stall) takes one item: func (insert, search,
// delete) and a signed key. Output channel (out_valid/out_stall) returns one
// item per input: status and slot_index.
// An item is taken only while the block is idle. The home slot is found by
// reciprocal multiply, multiply-subtract and final correction, then the slot
// memory is probed one slot per cycle through its single read port, the next
// read issued while the current entry is checked. The result then moves to
// the output register, and the next item is taken only once it is there. An
// unused func code skips the hash and the probe and answers not found.
// The result sits in an output register; while the receiver stalls, the
// block still takes and works the next item and holds its result internally
// until the output register frees up.
// After reset the block runs a clearing pass that marks every slot empty;
// in_stall is high during the pass.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic signed [KEY_W-1:0] key,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [SLOT_INDEX_W-1:0] slot_index
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_CHECK = 5'b01000,
        S_PUT   = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              func_reg, func_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [SW-1:0]           probe_reg, probe_next;
    logic [SW-1:0]           count_reg, count_next;
    logic [SW-1:0]           clr_reg, clr_next;
    status_t                 res_status_reg, res_status_next;
    logic [SW-1:0]           res_slot_reg, res_slot_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg, status_next;
    logic [SLOT_INDEX_W-1:0] slot_index_reg, slot_index_next;

    logic                       hash_start;
    logic                       hash_done;
    logic [SW-1:0]              home;
    logic [SW-1:0]              slot_after;
    logic                       last_probe;
    logic                       key_hit;
    logic [SW+SLOT_INDEX_W-1:0] res_slot_wide;

    logic          wr_en;
    logic [SW-1:0] wr_addr;
    entry_t        wr_data;
    logic [SW-1:0] rd_addr;
    entry_t        rd_data_reg;
    entry_t        mem [SLOT_COUNT];

    lph_home_slot #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_home_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .home  (home)
    );

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign slot_after    = (probe_reg == LAST_SLOT) ? '0 : probe_reg + 1'b1;
    assign last_probe    = (count_reg == LAST_SLOT);
    assign key_hit       = rd_data_reg.valid && (rd_data_reg.key == key_reg);
    assign res_slot_wide = {{SLOT_INDEX_W{1'b0}}, res_slot_reg};

    assign in_stall   = (state_reg != S_IDLE);
    assign hash_start = (state_reg == S_IDLE) && in_valid
                        && ((func_t'(func) == FUNC_INSERT)
                            || (func_t'(func) == FUNC_SEARCH)
                            || (func_t'(func) == FUNC_DELETE));

    // control and probe sequencing
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        slot_index_next = slot_index_reg;
        wr_en           = 1'b0;
        wr_addr         = probe_reg;
        wr_data.valid   = 1'b1;
        wr_data.key     = key_reg;
        rd_addr         = probe_reg;

        // output item taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_reg;
                wr_data.valid = 1'b0;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    key_next  = key;
                    if (hash_start)
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                        res_slot_next   = '0;
                        state_next      = S_PUT;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    probe_next = home;
                    count_next = '0;
                    rd_addr    = home;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // default: move on to the next slot
                probe_next = slot_after;
                rd_addr    = slot_after;
                count_next = count_reg + 1'b1;
                case (func_t'(func_reg))
                    FUNC_INSERT:
                    begin
                        if (!rd_data_reg.valid)
                        begin
                            wr_en           = 1'b1;
                            res_status_next = ST_OK;
                            res_slot_next   = probe_reg;
                            state_next      = S_PUT;
                        end
                        else if (last_probe)
                        begin
                            res_status_next = ST_FULL;
                            res_slot_next   = '0;
                            state_next      = S_PUT;
                        end
                    end
                    FUNC_SEARCH, FUNC_DELETE:
                    begin
                        if (key_hit)
                        begin
                            if (func_t'(func_reg) == FUNC_DELETE)
                            begin
                                wr_en         = 1'b1;
                                wr_data.valid = 1'b0;
                            end
                            res_status_next = ST_OK;
                            res_slot_next   = probe_reg;
                            state_next      = S_PUT;
                        end
                        else if (!rd_data_reg.valid || last_probe)
                        begin
                            res_status_next = ST_MISS;
                            res_slot_next   = '0;
                            state_next      = S_PUT;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_MISS;
                        res_slot_next   = '0;
                        state_next      = S_PUT;
                    end
                endcase
            end
            S_PUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    slot_index_next = res_slot_wide[SLOT_INDEX_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        probe_reg      <= probe_next;
        count_reg      <= count_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        status_reg     <= status_next;
        slot_index_reg <= slot_index_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_index_reg;

endmodule

>>> test/testbench.sv
module testbench;
    import lph_pkg::*;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        status_t         status;
        logic [3:0]      slot;
    } result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              status;
    logic [SLOT_INDEX_W-1:0] slot_index;

    // shadow copy of the slot store
    logic [31:0] slot_keys [SLOTS];
    logic        slot_used [SLOTS];

    result_t pending_results [$];
    int      error_count = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    bit      hold_req = 1'b0;

    linear_probe_hash_table #(
        .SLOT_COUNT(SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot_index (slot_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // insert, search or delete on the shadow table, giving the expected result
    function automatic void apply_table_op(input logic [1:0] op, input logic [31:0] k,
                                           output status_t st, output logic [3:0] idx);
        int s;
        st  = ST_MISS;
        idx = '0;
        s   = k[31] ? 0 : int'(k % 32'(SLOTS));
        case (op)
            FUNC_INSERT:
            begin
                st = ST_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_used[s])
                    begin
                        slot_keys[s] = k;
                        slot_used[s] = 1'b1;
                        st  = ST_OK;
                        idx = 4'(s);
                        break;
                    end
                    s = (s + 1) % SLOTS;
                end
            end
            FUNC_SEARCH, FUNC_DELETE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_used[s])
                        break;
                    if (slot_keys[s] == k)
                    begin
                        st  = ST_OK;
                        idx = 4'(s);
                        if (op == FUNC_DELETE)
                            slot_used[s] = 1'b0;
                        break;
                    end
                    s = (s + 1) % SLOTS;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // mostly keys already stored, then small colliding keys, then anything
    function automatic logic [31:0] pick_key();
        int live [$];
        int roll;
        foreach (slot_used[i])
            if (slot_used[i])
                live.push_back(i);
        roll = $urandom_range(99);
        if (live.size() > 0 && roll < 50)
            return slot_keys[live[$urandom_range(live.size() - 1)]];
        else if (roll < 80)
            return 32'(int'($urandom_range(40)) - 8);
        else
            return $urandom();
    endfunction

    function automatic logic [1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return FUNC_INSERT;
        else if (roll < 70)
            return FUNC_SEARCH;
        else if (roll < 95)
            return FUNC_DELETE;
        else
            return FUNC_UNUSED;
    endfunction

    // offer one item from a falling edge, record its expected result, then maybe idle
    task automatic send_item(input logic [1:0] op, input logic [31:0] k);
        result_t r;
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        do
            @(posedge clk);
        while (in_stall);
        apply_table_op(op, k, r.status, r.slot);
        pending_results.push_back(r);
        @(negedge clk);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            func     <= 2'($urandom());
            key      <= $urandom();
            do
                @(negedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // edge cases on a fresh table: empty home, wrap-around, negatives, duplicates
    task automatic test_directed_cases();
        send_item(FUNC_SEARCH, 32'd0);
        send_item(FUNC_DELETE, 32'd7);
        send_item(FUNC_UNUSED, 32'd0);
        send_item(FUNC_INSERT, 32'd0);
        send_item(FUNC_INSERT, 32'h8000_0000);
        send_item(FUNC_INSERT, 32'h7fff_ffff);
        send_item(FUNC_INSERT, 32'd31);
        send_item(FUNC_SEARCH, 32'd31);
        send_item(FUNC_SEARCH, 32'h8000_0000);
        send_item(FUNC_SEARCH, 32'hffff_ffff);
        send_item(FUNC_DELETE, 32'd0);
        send_item(FUNC_SEARCH, 32'd31);
        send_item(FUNC_INSERT, 32'd5);
        send_item(FUNC_INSERT, 32'd5);
        send_item(FUNC_DELETE, 32'd5);
        send_item(FUNC_SEARCH, 32'd5);
        send_item(FUNC_INSERT, 32'd21);
        send_item(FUNC_SEARCH, 32'd5);
        send_item(FUNC_UNUSED, 32'hffff_ffff);
        send_item(FUNC_DELETE, 32'h7fff_ffff);
    endtask

    // fill every slot, miss over a full lap, overflow, then delete each stored key
    task automatic test_full_table();
        int empties;
        empties = 0;
        foreach (slot_used[i])
            if (!slot_used[i])
                empties++;
        repeat (empties)
            send_item(FUNC_INSERT, 32'($urandom_range(999)));
        send_item(FUNC_INSERT, $urandom());
        send_item(FUNC_SEARCH, 32'd5000);
        send_item(FUNC_DELETE, 32'd5000);
        send_item(FUNC_INSERT, 32'h8000_0000 | $urandom());
        for (int i = SLOTS - 1; i >= 0; i--)
            send_item(FUNC_DELETE, slot_keys[i]);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            send_item(pick_op(), pick_key());
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (12)
            send_item(pick_op(), pick_key());
    endtask

    // receiver stall, with an occasional long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d slot %0d",
                         $time, status, slot_index);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, exp_r.status, status);
                    error_count++;
                end
                if (slot_index !== exp_r.slot)
                begin
                    $display("%0t: slot_index mismatch: expected %0d, got %0d",
                             $time, exp_r.slot, slot_index);
                    error_count++;
                end
            end
        end
    end

    // stop a hung run: too many cycles with no item moving on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FUNC_INSERT;
        key      = '0;
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
            slot_keys[i] = '0;
        end
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_directed_cases();
        test_full_table();
        test_random_traffic(110);
        set_idling(77, 0);
        test_random_traffic(110);
        set_idling(0, 77);
        test_random_traffic(110);
        set_idling(38, 38);
        test_random_traffic(110);
        set_idling(0, 0);
        test_output_backpressure();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
